// ===== rtl/core/kmc_pkg.sv =====
// Package for the 2D k-means block: payload structs, sizing constants, FSM states.
// No dependencies.
`default_nettype none
package kmc_pkg;
  localparam int MaxPointsDef = 32;
  localparam int MaxCentroidsDef = 8;
  localparam int CoordW = 16;
  localparam int IterW = 10;
  localparam logic [IterW-1:0] IterReset = 10'd100;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoCentroid = 2'd1;
  localparam logic [1:0] StDropped = 2'd2;

  localparam logic ModePoint = 1'b0;
  localparam logic KindLabel = 1'b0;
  localparam logic KindCentroid = 1'b1;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic              final_item;
  } in_req_t;

  typedef struct packed {
    logic              kind;
    logic [4:0]        item_index;
    logic [2:0]        cluster_label;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic              run_end;
    logic [1:0]        status;
  } out_req_t;

  typedef enum logic [3:0] {
    S_LOAD, S_ERR, S_ASG_RD, S_ASG_CMP, S_ASG_WR, S_UPD_RD, S_UPD_ACC,
    S_DIV, S_DIV_WR, S_EMIT_PT, S_EMIT_CT, S_EMIT_WAIT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/kmc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kmc_ram #(
  parameter int Width = 16,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/kmc_div.sv =====
// Restoring divider for signed sums by an unsigned count, truncation toward zero.
// No dependencies.
`default_nettype none
module kmc_div #(
  parameter int NumW = 22,
  parameter int DenW = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [NumW-1:0] num,
  input  wire logic [DenW-1:0]        den,
  output logic                        done,
  output logic signed [NumW-1:0]      quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW-1:0] rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic            neg_r, busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DenW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    trial = {rem_r, q_r[NumW-1]};
    if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DenW'(trial - {1'b0, den_r});
        q_nxt = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = DenW'(trial);
        q_nxt = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy_r && !busy_nxt;
      busy_r <= start ? 1'b1 : busy_nxt;
    end
    if (start) begin
      q_r <= num[NumW-1] ? NumW'(-num) : NumW'(num);
      neg_r <= num[NumW-1];
      den_r <= den;
      rem_r <= '0;
      cnt_r <= CntW'(NumW);
    end else begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

// ===== rtl/core/kmeans_2d_clustering.sv =====
// Top level of the 2D Lloyd k-means block: load, iterate, emit.
// Depends on kmc_pkg, kmc_ram, kmc_div.
//
//  channel | ports                       | direction
//  in      | in_valid, in_stall, in_data | request in, stall out
//  out     | out_valid, out_stall, out_data | request out, stall in
//  cfg     | cfg_valid, cfg_ready, cfg_data | register write in
//
// Loading accepts one request per cycle. An iteration assigns every point to its
// nearest centroid, then updates each centroid, paced by the single read port of
// the point memories and the 22-step serial divider run once for x and once for y
// (skipped without members). Each result is read from memory before it is shown.
// Reset clears FSM, counts and flags and restores the default iteration setting.
// Input stalls during a job and emission; output stalls hold the emitter.
`default_nettype none
module kmeans_2d_clustering #(
  parameter int MaxPoints = kmc_pkg::MaxPointsDef,
  parameter int MaxCentroids = kmc_pkg::MaxCentroidsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire kmc_pkg::in_req_t    in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output kmc_pkg::out_req_t        out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [kmc_pkg::IterW-1:0] cfg_data
);
  import kmc_pkg::*;
  localparam int PW = $clog2(MaxPoints + 1);
  localparam int PA = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CW = $clog2(MaxCentroids + 1);
  localparam int CA = (MaxCentroids > 1) ? $clog2(MaxCentroids) : 1;
  localparam int SumW = CoordW + PW;
  localparam int DistW = 2 * (CoordW + 1) + 1;

  state_t state_r, state_nxt;
  logic [IterW-1:0] iters_r, iter_r, iter_nxt;
  logic [PW-1:0] pcnt_r, pcnt_nxt, pi_r, pi_nxt;
  logic [CW-1:0] ccnt_r, ccnt_nxt, cj_r, cj_nxt;
  logic ovf_r, ovf_nxt;
  logic signed [SumW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [PW-1:0] mcnt_r, mcnt_nxt;
  logic [DistW-1:0] best_r, best_nxt;
  logic [CA-1:0] bi_r, bi_nxt;
  logic rd_ok_r, rd_ok_nxt, ydone_r, ydone_nxt;
  logic signed [CoordW-1:0] qx_r, qx_nxt;

  logic pw_e, lw_e, cw_e;
  logic [PA-1:0] pw_a, p_ra;
  logic [CA-1:0] cw_a, c_ra;
  logic [CoordW-1:0] cw_x, cw_y, px_q, py_q, cx_q, cy_q;
  logic [2:0] lw_d, l_q;

  kmc_ram #(.Width(CoordW), .Depth(MaxPoints)) u_px (.clk, .we(pw_e), .waddr(pw_a),
    .wdata(in_data.coord_x), .raddr(p_ra), .rdata(px_q));
  kmc_ram #(.Width(CoordW), .Depth(MaxPoints)) u_py (.clk, .we(pw_e), .waddr(pw_a),
    .wdata(in_data.coord_y), .raddr(p_ra), .rdata(py_q));
  kmc_ram #(.Width(3), .Depth(MaxPoints)) u_pl (.clk, .we(lw_e), .waddr(pi_r[PA-1:0]),
    .wdata(lw_d), .raddr(p_ra), .rdata(l_q));
  kmc_ram #(.Width(CoordW), .Depth(MaxCentroids)) u_cx (.clk, .we(cw_e), .waddr(cw_a),
    .wdata(cw_x), .raddr(c_ra), .rdata(cx_q));
  kmc_ram #(.Width(CoordW), .Depth(MaxCentroids)) u_cy (.clk, .we(cw_e), .waddr(cw_a),
    .wdata(cw_y), .raddr(c_ra), .rdata(cy_q));

  logic div_start, div_done;
  logic signed [SumW-1:0] div_q;
  kmc_div #(.NumW(SumW), .DenW(PW)) u_div (.clk, .rst_n, .start(div_start),
    .num(ydone_r ? sy_r : sx_r), .den(mcnt_r), .done(div_done), .quo(div_q));

  logic signed [CoordW:0] dx, dy;
  logic signed [2*CoordW+1:0] dx2, dy2;
  logic [DistW-1:0] sq_d;
  assign dx = $signed({px_q[CoordW-1], px_q}) - $signed({cx_q[CoordW-1], cx_q});
  assign dy = $signed({py_q[CoordW-1], py_q}) - $signed({cy_q[CoordW-1], cy_q});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign sq_d = DistW'($unsigned(dx2)) + DistW'($unsigned(dy2));

  logic [1:0] st;
  assign st = ovf_r ? StDropped : StOk;
  logic acc;
  assign acc = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_LOAD);
  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    state_nxt = state_r;
    iter_nxt = iter_r; pcnt_nxt = pcnt_r; ccnt_nxt = ccnt_r; ovf_nxt = ovf_r;
    pi_nxt = pi_r; cj_nxt = cj_r; sx_nxt = sx_r; sy_nxt = sy_r; mcnt_nxt = mcnt_r;
    best_nxt = best_r; bi_nxt = bi_r; rd_ok_nxt = 1'b0; ydone_nxt = ydone_r;
    qx_nxt = qx_r;
    pw_e = 1'b0; pw_a = pcnt_r[PA-1:0]; lw_e = 1'b0; lw_d = '0;
    cw_e = 1'b0; cw_a = ccnt_r[CA-1:0]; cw_x = in_data.coord_x; cw_y = in_data.coord_y;
    p_ra = pi_r[PA-1:0]; c_ra = cj_r[CA-1:0];
    div_start = 1'b0;
    out_valid = 1'b0; out_data = '0;
    unique case (state_r)
      S_LOAD: if (acc) begin
        if (in_data.mode == ModePoint) begin
          if (pcnt_r < PW'(MaxPoints)) begin
            pw_e = 1'b1; pcnt_nxt = pcnt_r + 1'b1;
          end else ovf_nxt = 1'b1;
        end else begin
          if (ccnt_r < CW'(MaxCentroids)) begin
            cw_e = 1'b1; ccnt_nxt = ccnt_r + 1'b1;
          end else ovf_nxt = 1'b1;
        end
        if (in_data.final_item) begin
          iter_nxt = '0; pi_nxt = '0; cj_nxt = '0;
          if (ccnt_nxt == '0) state_nxt = S_ERR;
          else if (iters_r == '0 || pcnt_nxt == '0) state_nxt = S_EMIT_PT;
          else state_nxt = S_ASG_RD;
        end
      end
      S_ERR: begin
        out_valid = 1'b1;
        out_data.run_end = 1'b1; out_data.status = StNoCentroid;
        if (!out_stall) begin
          state_nxt = S_LOAD; pcnt_nxt = '0; ccnt_nxt = '0; ovf_nxt = 1'b0;
        end
      end
      S_ASG_RD: begin
        cj_nxt = '0; best_nxt = '1; bi_nxt = '0;
        c_ra = '0; state_nxt = S_ASG_CMP; rd_ok_nxt = 1'b1;
      end
      S_ASG_CMP: begin
        if (sq_d < best_r || cj_r == '0) begin
          best_nxt = sq_d; bi_nxt = cj_r[CA-1:0];
        end
        c_ra = CA'(cj_r + 1'b1);
        cj_nxt = cj_r + 1'b1;
        if (cj_r + 1'b1 == ccnt_r) state_nxt = S_ASG_WR;
      end
      S_ASG_WR: begin
        lw_e = 1'b1; lw_d = 3'(bi_r);
        if (pi_r + 1'b1 == pcnt_r) begin
          pi_nxt = '0; cj_nxt = '0; state_nxt = S_UPD_RD;
        end else begin
          pi_nxt = pi_r + 1'b1; p_ra = PA'(pi_r + 1'b1); state_nxt = S_ASG_RD;
        end
      end
      S_UPD_RD: begin
        sx_nxt = '0; sy_nxt = '0; mcnt_nxt = '0; pi_nxt = '0; p_ra = '0;
        state_nxt = S_UPD_ACC;
      end
      S_UPD_ACC: begin
        if (l_q == 3'(cj_r)) begin
          sx_nxt = sx_r + SumW'($signed(px_q));
          sy_nxt = sy_r + SumW'($signed(py_q));
          mcnt_nxt = mcnt_r + 1'b1;
        end
        p_ra = PA'(pi_r + 1'b1);
        pi_nxt = pi_r + 1'b1;
        if (pi_r + 1'b1 == pcnt_r) begin
          pi_nxt = '0;
          if (mcnt_nxt == '0) begin
            state_nxt = S_DIV_WR;
          end else begin
            ydone_nxt = 1'b0; state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!rd_ok_r && !div_done) begin
          div_start = 1'b1; rd_ok_nxt = 1'b1;
        end else if (div_done) begin
          if (!ydone_r) begin
            qx_nxt = CoordW'(div_q); ydone_nxt = 1'b1;
          end else begin
            cw_e = 1'b1; cw_a = cj_r[CA-1:0];
            cw_x = qx_r; cw_y = CoordW'(div_q);
            ydone_nxt = 1'b0; state_nxt = S_DIV_WR;
          end
        end else rd_ok_nxt = 1'b1;
      end
      S_DIV_WR: begin
        p_ra = '0;
        if (cj_r + 1'b1 == ccnt_r) begin
          cj_nxt = '0; pi_nxt = '0;
          iter_nxt = iter_r + 1'b1;
          state_nxt = (iter_r + 1'b1 == iters_r) ? S_EMIT_WAIT : S_ASG_RD;
        end else begin
          cj_nxt = cj_r + 1'b1; state_nxt = S_UPD_RD;
        end
      end
      S_EMIT_WAIT: begin
        state_nxt = S_EMIT_PT;
      end
      S_EMIT_PT: begin
        if (pi_r == pcnt_r) begin
          state_nxt = S_EMIT_CT;
        end else if (rd_ok_r) begin
          out_valid = 1'b1;
          out_data.kind = KindLabel; out_data.item_index = 5'(pi_r);
          out_data.cluster_label = (iters_r == '0) ? 3'd0 : l_q;
          out_data.out_x = px_q; out_data.out_y = py_q; out_data.status = st;
          if (!out_stall) begin
            pi_nxt = pi_r + 1'b1; p_ra = PA'(pi_r + 1'b1);
          end else rd_ok_nxt = 1'b1;
          rd_ok_nxt = out_stall;
        end else rd_ok_nxt = 1'b1;
      end
      S_EMIT_CT: begin
        if (rd_ok_r) begin
          out_valid = 1'b1;
          out_data.kind = KindCentroid; out_data.item_index = 5'(cj_r);
          out_data.out_x = cx_q; out_data.out_y = cy_q; out_data.status = st;
          out_data.run_end = (cj_r + 1'b1 == ccnt_r);
          rd_ok_nxt = out_stall;
          if (!out_stall) begin
            cj_nxt = cj_r + 1'b1; c_ra = CA'(cj_r + 1'b1);
            if (cj_r + 1'b1 == ccnt_r) begin
              state_nxt = S_LOAD; pcnt_nxt = '0; ccnt_nxt = '0; ovf_nxt = 1'b0;
              pi_nxt = '0; cj_nxt = '0;
            end
          end
        end else rd_ok_nxt = 1'b1;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; iters_r <= IterReset; iter_r <= '0;
      pcnt_r <= '0; ccnt_r <= '0; ovf_r <= 1'b0; pi_r <= '0; cj_r <= '0;
      rd_ok_r <= 1'b0; ydone_r <= 1'b0; mcnt_r <= '0;
    end else begin
      state_r <= state_nxt; iter_r <= iter_nxt;
      pcnt_r <= pcnt_nxt; ccnt_r <= ccnt_nxt; ovf_r <= ovf_nxt;
      pi_r <= pi_nxt; cj_r <= cj_nxt; rd_ok_r <= rd_ok_nxt; ydone_r <= ydone_nxt;
      mcnt_r <= mcnt_nxt;
      if (cfg_valid && cfg_ready) iters_r <= cfg_data;
    end
    sx_r <= sx_nxt; sy_r <= sy_nxt; best_r <= best_nxt; bi_r <= bi_nxt; qx_r <= qx_nxt;
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for kmeans_2d_clustering: directed and random jobs,
// an in-bench Lloyd k-means predictor and an in-order result checker.
// Depends on kmc_pkg and the kmeans_2d_clustering RTL.
`timescale 1ns / 100ps
module tb;
  import kmc_pkg::*;

  localparam int NumPts = 32;
  localparam int NumCtr = 8;
  localparam longint CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IterW-1:0] cfg_data = '0;

  kmeans_2d_clustering u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // clustering model state
  int unsigned iter_setting = IterReset;
  logic signed [15:0] pt_x [NumPts];
  logic signed [15:0] pt_y [NumPts];
  logic [2:0] pt_lab [NumPts];
  logic signed [15:0] ct_x [NumCtr];
  logic signed [15:0] ct_y [NumCtr];
  int unsigned pt_cnt = 0;
  int unsigned ct_cnt = 0;
  bit dropped = 0;

  out_req_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned sent = 0;
  longint cycles = 0;

  task automatic report(input string what, input out_req_t got, input out_req_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic out_req_t make_res(logic kind, int unsigned idx, logic [2:0] lab,
                                        logic signed [15:0] x, logic signed [15:0] y,
                                        logic last, logic [1:0] st);
    out_req_t r;
    r.kind = kind;
    r.item_index = idx[4:0];
    r.cluster_label = lab;
    r.out_x = x;
    r.out_y = y;
    r.run_end = last;
    r.status = st;
    return r;
  endfunction

  function automatic longint sq_dist(int unsigned p, int unsigned c);
    longint dx, dy;
    dx = longint'(pt_x[p]) - longint'(ct_x[c]);
    dy = longint'(pt_y[p]) - longint'(ct_y[c]);
    return dx * dx + dy * dy;
  endfunction

  task automatic cluster_request(input in_req_t req);
    longint best, d, sx, sy, n;
    int unsigned bi;
    logic [1:0] st;
    if (req.mode == ModePoint) begin
      if (pt_cnt < NumPts) begin
        pt_x[pt_cnt] = req.coord_x;
        pt_y[pt_cnt] = req.coord_y;
        pt_cnt++;
      end else dropped = 1;
    end else begin
      if (ct_cnt < NumCtr) begin
        ct_x[ct_cnt] = req.coord_x;
        ct_y[ct_cnt] = req.coord_y;
        ct_cnt++;
      end else dropped = 1;
    end
    if (!req.final_item) return;
    if (ct_cnt == 0) begin
      expected_results.push_back(make_res(KindLabel, 0, 0, 0, 0, 1'b1, StNoCentroid));
    end else begin
      for (int i = 0; i < pt_cnt; i++) pt_lab[i] = 0;
      for (int it = 0; it < iter_setting; it++) begin
        for (int i = 0; i < pt_cnt; i++) begin
          best = sq_dist(i, 0);
          bi = 0;
          for (int j = 1; j < ct_cnt; j++) begin
            d = sq_dist(i, j);
            if (d < best) begin
              best = d;
              bi = j;
            end
          end
          pt_lab[i] = bi[2:0];
        end
        for (int j = 0; j < ct_cnt; j++) begin
          sx = 0; sy = 0; n = 0;
          for (int i = 0; i < pt_cnt; i++) begin
            if (pt_lab[i] == j) begin
              sx += pt_x[i];
              sy += pt_y[i];
              n++;
            end
          end
          if (n > 0) begin
            ct_x[j] = 16'(sx / n);
            ct_y[j] = 16'(sy / n);
          end
        end
      end
      st = dropped ? StDropped : StOk;
      for (int i = 0; i < pt_cnt; i++)
        expected_results.push_back(make_res(KindLabel, i, pt_lab[i], pt_x[i], pt_y[i],
                                            1'b0, st));
      for (int j = 0; j < ct_cnt; j++)
        expected_results.push_back(make_res(KindCentroid, j, 0, ct_x[j], ct_y[j],
                                            j + 1 == ct_cnt, st));
    end
    pt_cnt = 0;
    ct_cnt = 0;
    dropped = 0;
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_request(input logic mode, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic last);
    in_req_t req;
    req.mode = mode;
    req.coord_x = x;
    req.coord_y = y;
    req.final_item = last;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cluster_request(req);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_iterations(input int unsigned v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v[IterW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    iter_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(input bit near);
    if (near) return 16'($signed($urandom_range(4000)) - 2000);
    return 16'($urandom);
  endfunction

  // send np points and nc centroids in random order, final on the last
  task automatic send_job(input int unsigned np, input int unsigned nc, input bit near);
    int unsigned p, c;
    logic m;
    p = np;
    c = nc;
    while (p + c > 0) begin
      m = (c > 0) && ($urandom_range(p + c - 1) < c);
      if (m) c--; else p--;
      send_request(m, rand_coord(near), rand_coord(near), p + c == 0);
    end
  endtask

  task automatic test_extremes();
    set_iterations(2);
    send_request(1'b1, 16'sh7fff, 16'sh8000, 1'b0);
    send_request(1'b1, 16'sh8000, 16'sh7fff, 1'b0);
    send_request(1'b0, 16'sh8000, 16'sh8000, 1'b0);
    send_request(1'b0, 16'sh7fff, 16'sh7fff, 1'b0);
    send_request(1'b0, 16'sh0000, 16'sh0000, 1'b1);
  endtask

  task automatic test_tie_and_empty();
    set_iterations(1023);
    send_request(1'b1, -16'sd100, 16'sd0, 1'b0);
    send_request(1'b1, 16'sd100, 16'sd0, 1'b0);
    send_request(1'b1, 16'sd30000, 16'sd30000, 1'b0);
    send_request(1'b0, 16'sd0, 16'sd5, 1'b0);
    send_request(1'b0, -16'sd7, -16'sd3, 1'b1);
  endtask

  task automatic test_zero_iterations();
    set_iterations(0);
    send_job(4, 3, 1);
  endtask

  task automatic test_no_centroids();
    set_iterations(5);
    send_request(1'b0, 16'sd1, 16'sd2, 1'b1);
    send_request(1'b0, 16'sd1, 16'sd2, 1'b0);
    send_request(1'b0, 16'sd3, 16'sd4, 1'b1);
  endtask

  task automatic test_no_points();
    send_request(1'b1, 16'sd9, -16'sd9, 1'b1);
    send_job(0, 2, 0);
  endtask

  task automatic test_capacity();
    set_iterations(1);
    send_job(NumPts + 2, NumCtr + 1, 1);
    send_job(0, 0, 0);
    for (int i = 0; i < NumPts + 1; i++) send_request(1'b0, rand_coord(0), rand_coord(0), 1'b0);
    send_request(1'b0, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_back_pressure();
    set_iterations(3);
    hold_cycles = 4000;
    send_job(NumPts, NumCtr, 1);
    send_job(6, 2, 1);
    send_job(5, 3, 1);
    drain_results();
  endtask

  task automatic test_random(input int unsigned target);
    int unsigned np, nc, r;
    while (sent < target) begin
      r = $urandom_range(99);
      nc = $urandom_range(NumCtr, 1);
      np = ($urandom_range(9) == 0) ? $urandom_range(NumPts) : $urandom_range(10);
      if (r < 5) nc = 0;
      else if (r < 9) begin
        np = NumPts + $urandom_range(3);
        nc = NumCtr + $urandom_range(1);
      end
      if (np + nc == 0) np = 1;
      send_job(np, nc, $urandom_range(1));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_tie_and_empty();
    test_zero_iterations();
    test_no_centroids();
    test_no_points();
    test_capacity();
    test_back_pressure();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 80 : (ph == 3) ? 29 : 0;
      stall_pct = (ph == 2) ? 80 : (ph == 3) ? 29 : 0;
      set_iterations((ph == 0) ? 100 : $urandom_range(12));
      test_random(sent + 40);
    end
    drain_results();
    if (mismatches == 0) begin
      $display("[kmeans_2d_clustering] OK");
    end else begin
      $display("[kmeans_2d_clustering] ERROR");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected", out_data, '0);
      end else begin
        if (out_data.kind != expected_results[0].kind)
          report("kind", out_data, expected_results[0]);
        if (out_data.item_index != expected_results[0].item_index)
          report("item_index", out_data, expected_results[0]);
        if (out_data.cluster_label != expected_results[0].cluster_label)
          report("cluster_label", out_data, expected_results[0]);
        if (out_data.out_x != expected_results[0].out_x)
          report("out_x", out_data, expected_results[0]);
        if (out_data.out_y != expected_results[0].out_y)
          report("out_y", out_data, expected_results[0]);
        if (out_data.run_end != expected_results[0].run_end)
          report("run_end", out_data, expected_results[0]);
        if (out_data.status != expected_results[0].status)
          report("status", out_data, expected_results[0]);
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[kmeans_2d_clustering] ERROR");
      $finish;
    end
  end
endmodule

// ===== files.f =====
rtl/core/kmc_pkg.sv
rtl/core/kmc_ram.sv
rtl/core/kmc_div.sv
rtl/core/kmeans_2d_clustering.sv
tb/sv/tb.sv
